// ===== sv/mst_pkg.sv =====
`default_nettype none

package mst_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 16;
    localparam int MODE_W   = 2;
    localparam int IVL_W    = 32;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 64;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REG   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNREG = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_EVERY    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNREG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;

    typedef struct packed {
        logic load;
        logic read;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ext;
        logic              quick_fail;
        logic              hit;
        logic              idx_last;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/multi_slot_software_timer_top.sv =====
`default_nettype none

// Channel   Signals                                                   Transfer
// -------   -------------------------------------------------------   -----------------------
// request   start, busy, i_func, i_client_tag, i_trigger_mode,         start && !busy
//           i_request_interval_us, i_ext_context
// result    o_strobe, o_kind, o_ok, o_slot, o_fired_tag, o_last        o_strobe, one cycle
// config    i_cfg_valid, o_cfg_ready, i_cfg_data                       i_cfg_valid && o_cfg_ready
//
// A tick without extended context ends after the decide state; a request whose reply is known
// at once passes decide and finish. A scanning request walks the slot memory with one read per
// cycle, through drain and finish unless a hit ends it early.
// Reset is synchronous and active low; the slot table needs no clearing pass.
// Results are shown for one cycle each and cannot be stalled.

module multi_slot_software_timer_top #(
    parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mst_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [mst_pkg::TAG_W-1:0]     i_client_tag,
    input  wire logic [mst_pkg::MODE_W-1:0]    i_trigger_mode,
    input  wire logic [mst_pkg::IVL_W-1:0]     i_request_interval_us,
    input  wire logic                          i_ext_context,
    output logic                               o_strobe,
    output logic [mst_pkg::KIND_W-1:0]         o_kind,
    output logic                               o_ok,
    output logic [mst_pkg::SLOT_W-1:0]         o_slot,
    output logic [mst_pkg::TAG_W-1:0]          o_fired_tag,
    output logic                               o_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mst_pkg::PERIOD_W-1:0]  i_cfg_data
);

    mst_pkg::t_cmd    cmd;
    mst_pkg::t_status status;

    assign o_cfg_ready = !busy;

    mst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mst_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_cfg_we              (i_cfg_valid && o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .i_func                (i_func),
        .i_client_tag          (i_client_tag),
        .i_trigger_mode        (i_trigger_mode),
        .i_request_interval_us (i_request_interval_us),
        .i_ext_context         (i_ext_context),
        .o_strobe              (o_strobe),
        .o_kind                (o_kind),
        .o_ok                  (o_ok),
        .o_slot                (o_slot),
        .o_fired_tag           (o_fired_tag),
        .o_last                (o_last)
    );

endmodule

`default_nettype wire

// ===== sv/mst_ctrl.sv =====
`default_nettype none

module mst_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire mst_pkg::t_status i_status,
    output mst_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.func == mst_pkg::FUNC_NOP) begin
                    n_state = ST_IDLE;
                end else if (i_status.func == mst_pkg::FUNC_TICK) begin
                    n_state = i_status.ext ? ST_SCAN : ST_IDLE;
                end else if (i_status.quick_fail) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    n_state = ST_IDLE;
                end else if (i_status.idx_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load   = start && !r_busy;
        o_cmd.read   = (r_state == ST_SCAN);
        o_cmd.finish = (r_state == ST_FINISH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

`default_nettype wire

// ===== sv/mst_datapath.sv =====
`default_nettype none

module mst_datapath #(
    parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mst_pkg::t_cmd                 i_cmd,
    output mst_pkg::t_status                   o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [mst_pkg::PERIOD_W-1:0]  i_cfg_data,
    input  wire logic [mst_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [mst_pkg::TAG_W-1:0]     i_client_tag,
    input  wire logic [mst_pkg::MODE_W-1:0]    i_trigger_mode,
    input  wire logic [mst_pkg::IVL_W-1:0]     i_request_interval_us,
    input  wire logic                          i_ext_context,
    output logic                               o_strobe,
    output logic [mst_pkg::KIND_W-1:0]         o_kind,
    output logic                               o_ok,
    output logic [mst_pkg::SLOT_W-1:0]         o_slot,
    output logic [mst_pkg::TAG_W-1:0]          o_fired_tag,
    output logic                               o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = $clog2(SLOTS + 1);
    localparam int SW = mst_pkg::SLOT_W;
    localparam int TW = mst_pkg::TIME_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [AW-1:0] FULL     = AW'(SLOTS);

    typedef struct packed {
        logic [mst_pkg::TAG_W-1:0]  tag;
        logic [mst_pkg::MODE_W-1:0] mode;
        logic [mst_pkg::IVL_W-1:0]  ivl;
    } t_slot_cfg;

    typedef struct packed {
        logic [mst_pkg::KIND_W-1:0] kind;
        logic                       ok;
        logic [SW-1:0]              slot;
        logic [mst_pkg::TAG_W-1:0]  tag;
        logic                       last;
    } t_result;

    t_slot_cfg mem_cfg  [SLOTS];
    logic [TW-1:0] mem_last [SLOTS];

    logic [mst_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [TW-1:0]                r_tick_total, n_tick_total;
    logic [TW-1:0]                r_time_now, n_time_now;
    logic [SLOTS-1:0]             r_active, n_active;
    logic [AW-1:0]                r_active_total, n_active_total;

    logic [mst_pkg::FUNC_W-1:0]   r_func;
    logic [mst_pkg::TAG_W-1:0]    r_tag;
    logic [mst_pkg::MODE_W-1:0]   r_mode;
    logic [mst_pkg::IVL_W-1:0]    r_ivl;
    logic                         r_ext;

    logic [IW-1:0]                r_idx, n_idx;
    logic                         r_ev_valid;
    logic [IW-1:0]                r_ev_idx;
    t_slot_cfg                    r_rd_cfg;
    logic [TW-1:0]                r_rd_last;
    logic                         r_hit, n_hit;

    logic                         r_pend_valid, n_pend_valid;
    logic [IW-1:0]                r_pend_slot, n_pend_slot;
    logic [mst_pkg::TAG_W-1:0]    r_pend_tag, n_pend_tag;

    logic                         r_strobe, n_strobe;
    t_result                      r_res, n_res;

    logic                         eval_en;
    logic                         slot_act;
    logic [TW-1:0]                elapsed;
    logic                         due;
    logic                         fire;
    logic                         set_act;
    logic                         clr_act;
    logic                         wr_cfg;
    logic                         wr_last;
    t_slot_cfg                    new_cfg;

    assign eval_en  = r_ev_valid && !r_hit;
    assign slot_act = r_active[r_ev_idx];
    assign elapsed  = r_time_now - r_rd_last;
    assign due      = (elapsed >= TW'(r_rd_cfg.ivl));

    always_comb begin
        new_cfg.tag  = r_tag;
        new_cfg.mode = r_mode;
        new_cfg.ivl  = (r_mode == mst_pkg::MODE_EVERY) ?
                       mst_pkg::IVL_W'(r_period) : r_ivl;
    end

    always_comb begin
        n_period       = r_period;
        n_tick_total   = r_tick_total;
        n_time_now     = r_time_now;
        n_active       = r_active;
        n_active_total = r_active_total;
        n_idx          = r_idx;
        n_hit          = r_hit;
        n_pend_valid   = r_pend_valid;
        n_pend_slot    = r_pend_slot;
        n_pend_tag     = r_pend_tag;
        n_strobe       = 1'b0;
        n_res          = r_res;
        fire           = 1'b0;
        set_act        = 1'b0;
        clr_act        = 1'b0;
        wr_cfg         = 1'b0;
        wr_last        = 1'b0;

        case (r_func)
            mst_pkg::FUNC_REG: begin
                if (eval_en && !slot_act) begin
                    wr_cfg   = 1'b1;
                    wr_last  = 1'b1;
                    set_act  = 1'b1;
                    n_hit    = 1'b1;
                    n_strobe = 1'b1;
                    n_res    = '{mst_pkg::KIND_REG, 1'b1, SW'(r_ev_idx), '0, 1'b1};
                end
                if (i_cmd.finish && !r_hit) begin
                    n_strobe = 1'b1;
                    n_res    = '{mst_pkg::KIND_REG, 1'b0, '0, '0, 1'b1};
                end
            end
            mst_pkg::FUNC_UNREG: begin
                if (eval_en && slot_act && (r_rd_cfg.tag == r_tag)) begin
                    clr_act  = 1'b1;
                    n_hit    = 1'b1;
                    n_strobe = 1'b1;
                    n_res    = '{mst_pkg::KIND_UNREG, 1'b1, SW'(r_ev_idx), '0, 1'b1};
                end
                if (i_cmd.finish && !r_hit) begin
                    n_strobe = 1'b1;
                    n_res    = '{mst_pkg::KIND_UNREG, 1'b0, '0, '0, 1'b1};
                end
            end
            mst_pkg::FUNC_TICK: begin
                if (eval_en && slot_act) begin
                    case (r_rd_cfg.mode)
                        mst_pkg::MODE_EVERY: begin
                            fire = 1'b1;
                        end
                        mst_pkg::MODE_PERIODIC: begin
                            fire    = due;
                            wr_last = due;
                        end
                        mst_pkg::MODE_ONESHOT: begin
                            fire    = due;
                            clr_act = due;
                        end
                        default: begin
                            fire = 1'b0;
                        end
                    endcase
                end
                // A fire result is held back one find so that the final one can carry last.
                if (fire) begin
                    if (r_pend_valid) begin
                        n_strobe = 1'b1;
                        n_res    = '{mst_pkg::KIND_FIRED, 1'b1, SW'(r_pend_slot),
                                     r_pend_tag, 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_slot  = r_ev_idx;
                    n_pend_tag   = r_rd_cfg.tag;
                end
                if (i_cmd.finish && r_pend_valid) begin
                    n_strobe     = 1'b1;
                    n_res        = '{mst_pkg::KIND_FIRED, 1'b1, SW'(r_pend_slot),
                                     r_pend_tag, 1'b1};
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                fire = 1'b0;
            end
        endcase

        if (set_act) begin
            n_active[r_ev_idx] = 1'b1;
            n_active_total     = r_active_total + AW'(1);
        end
        if (clr_act) begin
            n_active[r_ev_idx] = 1'b0;
            if (r_active_total != '0) begin
                n_active_total = r_active_total - AW'(1);
            end
        end

        if (i_cmd.read) begin
            n_idx = r_idx + IW'(1);
        end

        if (i_cmd.load) begin
            n_idx        = '0;
            n_hit        = 1'b0;
            n_pend_valid = 1'b0;
            if (i_func == mst_pkg::FUNC_TICK) begin
                n_tick_total = r_tick_total + TW'(1);
                n_time_now   = r_time_now + TW'(r_period);
            end
        end

        if (i_cfg_we) begin
            n_period = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= mst_pkg::PERIOD_RESET;
            r_tick_total   <= '0;
            r_time_now     <= '0;
            r_active       <= '0;
            r_active_total <= '0;
            r_idx          <= '0;
            r_ev_valid     <= 1'b0;
            r_hit          <= 1'b0;
            r_pend_valid   <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_period       <= n_period;
            r_tick_total   <= n_tick_total;
            r_time_now     <= n_time_now;
            r_active       <= n_active;
            r_active_total <= n_active_total;
            r_idx          <= n_idx;
            r_ev_valid     <= i_cmd.read;
            r_hit          <= n_hit;
            r_pend_valid   <= n_pend_valid;
            r_strobe       <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_tag  <= i_client_tag;
            r_mode <= i_trigger_mode;
            r_ivl  <= i_request_interval_us;
            r_ext  <= i_ext_context;
        end
        r_ev_idx    <= r_idx;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        r_res       <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_cfg  <= mem_cfg[r_idx];
            r_rd_last <= mem_last[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_cfg) begin
            mem_cfg[r_ev_idx] <= new_cfg;
        end
        if (wr_last) begin
            mem_last[r_ev_idx] <= r_time_now;
        end
    end

    always_comb begin
        o_status.func       = r_func;
        o_status.ext        = r_ext;
        o_status.quick_fail = (r_tag == '0) ||
                              ((r_func == mst_pkg::FUNC_REG) && (r_active_total == FULL));
        o_status.hit        = r_hit;
        o_status.idx_last   = (r_idx == LAST_IDX);
    end

    assign o_strobe    = r_strobe;
    assign o_kind      = r_res.kind;
    assign o_ok        = r_res.ok;
    assign o_slot      = r_res.slot;
    assign o_fired_tag = r_res.tag;
    assign o_last      = r_res.last;

endmodule

`default_nettype wire

// ===== sv/mst_checker.sv =====
`default_nettype none

module mst_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [mst_pkg::FUNC_W-1:0]    i_func,
    input wire logic                          o_strobe,
    input wire logic [mst_pkg::KIND_W-1:0]    o_kind,
    input wire logic                          o_ok,
    input wire logic [mst_pkg::SLOT_W-1:0]    o_slot,
    input wire logic                          o_last
);

    // Only fire results can be followed by more results from the same transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind != mst_pkg::KIND_FIRED) |-> o_last)
        else $error("reply result without last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("intermediate result after the block went idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_ok |-> (o_slot == '0) && (o_kind != mst_pkg::KIND_FIRED))
        else $error("failed result with a slot or of fire kind");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_func == mst_pkg::FUNC_NOP) |=> !o_strobe ##1 !o_strobe)
        else $error("result caused by an unused function code");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("block not quiet after reset");

endmodule

bind multi_slot_software_timer_top mst_checker u_mst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_func   (i_func),
    .o_strobe (o_strobe),
    .o_kind   (o_kind),
    .o_ok     (o_ok),
    .o_slot   (o_slot),
    .o_last   (o_last)
);

`default_nettype wire
